/* hdl/tacc_pkg.sv */
// Shared types and codes for the triggered audio capture controller.
`default_nettype none

package tacc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int POS_W       = 17;
  localparam int THR_W       = 23;
  localparam int STOP_W      = 8;
  localparam int INDEX_W     = 16;
  localparam int FUNC_W      = 3;
  localparam int MODE_W      = 2;
  localparam int CFG_W       = 23;
  localparam int CFG_IDX_W   = 2;
  localparam int WORD_W      = 2 * SAMPLE_BITS;

  localparam logic [FUNC_W-1:0] FUNC_FRAME    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FINALIZE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REARM    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd5;

  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CAPT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BLOCK_COUNT = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]             func;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          host_playing;
    logic                          block_end;
    logic [INDEX_W-1:0]            read_index;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic                          finalize_wanted;
    logic                          analysis_pending;
    logic                          finalize_ok;
    logic [POS_W-1:0]              captured_frames;
    logic signed [SAMPLE_BITS-1:0] read_left;
    logic signed [SAMPLE_BITS-1:0] read_right;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              finalize_wanted;
    logic              analysis_pending;
    logic              finalize_ok;
    logic [POS_W-1:0]  captured_frames;
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [POS_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } store_req_t;

endpackage

`default_nettype wire

/* hdl/tacc_store.sv */
// Frame store: one write or one read per cycle, registered read data.
`default_nettype none

module tacc_store #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 48
) (
  input  wire logic                 clk,
  input  wire tacc_pkg::store_req_t req,
  output logic [WIDTH-1:0]          rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    addr;

  assign addr = AW'(req.addr);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= WIDTH'(req.wdata);
    end
    if (req.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/tacc_ctrl.sv */
// Capture state machine, configuration registers and store addressing.
`default_nettype none

module tacc_ctrl #(
  parameter int STORE_DEPTH   = 65536,
  parameter int CHANNEL_COUNT = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [tacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tacc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           step,
  input  wire tacc_pkg::in_item_t             item,
  output tacc_pkg::status_t                   status,
  output tacc_pkg::store_req_t                store_req,
  output logic                                read_hit
);

  localparam int SB = tacc_pkg::SAMPLE_BITS;

  logic [tacc_pkg::THR_W-1:0]  level_threshold;
  logic [tacc_pkg::POS_W-1:0]  capture_limit;
  logic [tacc_pkg::POS_W-1:0]  min_frames;
  logic [tacc_pkg::STOP_W-1:0] stop_block_count;

  logic [tacc_pkg::MODE_W-1:0] capture_mode, capture_mode_next;
  logic [tacc_pkg::POS_W-1:0]  write_position, write_position_next;
  logic [tacc_pkg::POS_W-1:0]  final_count, final_count_next;
  logic [tacc_pkg::STOP_W-1:0] stopped_blocks, stopped_blocks_next;
  logic                        finalize_request, finalize_request_next;
  logic                        dispatch_pending, dispatch_pending_next;
  logic                        block_loud, block_loud_next;
  logic [tacc_pkg::POS_W-1:0]  written_extent, written_extent_next;

  logic [tacc_pkg::POS_W-1:0] eff_limit;
  logic [tacc_pkg::POS_W-1:0] pos_inc;
  logic [tacc_pkg::POS_W-1:0] read_pos;
  logic [SB-1:0]              mag_l, mag_r;
  logic                       loud;
  logic                       clear;
  logic [tacc_pkg::MODE_W-1:0] clear_mode;
  logic                       ok;
  logic                       wr, rd;

  function automatic logic [SB-1:0] magnitude(input logic [SB-1:0] v);
    magnitude = v[SB-1] ? (~v + SB'(1)) : v;
  endfunction

  assign eff_limit = (32'(capture_limit) > 32'(STORE_DEPTH)) ?
                     tacc_pkg::POS_W'(STORE_DEPTH) : capture_limit;
  assign pos_inc   = write_position + tacc_pkg::POS_W'(1);
  assign read_pos  = tacc_pkg::POS_W'(item.read_index);
  assign mag_l     = magnitude(item.sample_left);
  assign mag_r     = magnitude(item.sample_right);

  always_comb begin
    capture_mode_next     = capture_mode;
    write_position_next   = write_position;
    final_count_next      = final_count;
    stopped_blocks_next   = stopped_blocks;
    finalize_request_next = finalize_request;
    dispatch_pending_next = dispatch_pending;
    block_loud_next       = block_loud;
    written_extent_next   = written_extent;
    loud       = 1'b0;
    clear      = 1'b0;
    clear_mode = tacc_pkg::MODE_WAIT;
    ok         = 1'b0;
    wr         = 1'b0;
    rd         = 1'b0;
    read_hit   = 1'b0;

    case (item.func)
      tacc_pkg::FUNC_FRAME: begin
        if (!dispatch_pending) begin
          if (capture_mode == tacc_pkg::MODE_WAIT) begin
            loud = block_loud | (item.host_playing &
                   ((mag_l > SB'(level_threshold)) ||
                    ((CHANNEL_COUNT >= 2) && (mag_r > SB'(level_threshold)))));
            block_loud_next = loud;
            if (item.block_end) begin
              block_loud_next = 1'b0;
              if (item.host_playing && loud) begin
                write_position_next   = '0;
                stopped_blocks_next   = '0;
                finalize_request_next = 1'b0;
                capture_mode_next     = tacc_pkg::MODE_CAPT;
              end
            end
          end else if (capture_mode == tacc_pkg::MODE_CAPT) begin
            if (item.block_end) begin
              block_loud_next = 1'b0;
            end
            if (item.host_playing) begin
              stopped_blocks_next = '0;
              if (write_position < eff_limit) begin
                wr                  = 1'b1;
                write_position_next = pos_inc;
                if (written_extent < pos_inc) begin
                  written_extent_next = pos_inc;
                end
              end
              if (write_position_next >= eff_limit) begin
                finalize_request_next = 1'b1;
              end
            end else if (item.block_end) begin
              // saturate the stopped-block run
              if (stopped_blocks != '1) begin
                stopped_blocks_next = stopped_blocks + tacc_pkg::STOP_W'(1);
              end
              if (stopped_blocks_next >= stop_block_count) begin
                finalize_request_next = 1'b1;
              end
            end
          end
        end
      end
      tacc_pkg::FUNC_FINALIZE: begin
        if (capture_mode == tacc_pkg::MODE_CAPT) begin
          if (write_position < min_frames) begin
            clear      = 1'b1;
            clear_mode = tacc_pkg::MODE_WAIT;
          end else begin
            final_count_next      = write_position;
            dispatch_pending_next = 1'b1;
            finalize_request_next = 1'b0;
            block_loud_next       = 1'b0;
            capture_mode_next     = tacc_pkg::MODE_DONE;
            ok                    = 1'b1;
          end
        end
      end
      tacc_pkg::FUNC_DISPATCH: begin
        dispatch_pending_next = 1'b0;
        finalize_request_next = 1'b0;
        stopped_blocks_next   = '0;
        block_loud_next       = 1'b0;
        capture_mode_next     = tacc_pkg::MODE_WAIT;
      end
      tacc_pkg::FUNC_STOP: begin
        clear      = 1'b1;
        clear_mode = tacc_pkg::MODE_IDLE;
      end
      tacc_pkg::FUNC_REARM: begin
        clear      = 1'b1;
        clear_mode = tacc_pkg::MODE_WAIT;
      end
      tacc_pkg::FUNC_READ: begin
        rd       = 1'b1;
        read_hit = (read_pos < written_extent) && (read_pos < eff_limit);
      end
      default: ;
    endcase

    // a clear drops the written extent, so old frames read as zero
    if (clear) begin
      written_extent_next   = '0;
      write_position_next   = '0;
      final_count_next      = '0;
      stopped_blocks_next   = '0;
      dispatch_pending_next = 1'b0;
      finalize_request_next = 1'b0;
      block_loud_next       = 1'b0;
      capture_mode_next     = clear_mode;
    end
  end

  always_comb begin
    status.mode             = capture_mode_next;
    status.finalize_wanted  = finalize_request_next;
    status.analysis_pending = dispatch_pending_next;
    status.finalize_ok      = ok;
    status.captured_frames  = (capture_mode_next == tacc_pkg::MODE_DONE) ?
                              final_count_next : write_position_next;
    store_req.wr_en = step & wr;
    store_req.rd_en = step & rd;
    store_req.addr  = rd ? read_pos : write_position;
    store_req.wdata = {item.sample_right, item.sample_left};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold  <= '0;
      capture_limit    <= tacc_pkg::POS_W'(65536);
      min_frames       <= '0;
      stop_block_count <= tacc_pkg::STOP_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        tacc_pkg::CFG_LEVEL_THRESHOLD:  level_threshold  <= cfg_data[tacc_pkg::THR_W-1:0];
        tacc_pkg::CFG_CAPTURE_LIMIT:    capture_limit    <= cfg_data[tacc_pkg::POS_W-1:0];
        tacc_pkg::CFG_MIN_FRAMES:       min_frames       <= cfg_data[tacc_pkg::POS_W-1:0];
        tacc_pkg::CFG_STOP_BLOCK_COUNT: stop_block_count <= cfg_data[tacc_pkg::STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_mode     <= tacc_pkg::MODE_WAIT;
      write_position   <= '0;
      final_count      <= '0;
      stopped_blocks   <= '0;
      finalize_request <= 1'b0;
      dispatch_pending <= 1'b0;
      block_loud       <= 1'b0;
      written_extent   <= '0;
    end else if (step) begin
      capture_mode     <= capture_mode_next;
      write_position   <= write_position_next;
      final_count      <= final_count_next;
      stopped_blocks   <= stopped_blocks_next;
      finalize_request <= finalize_request_next;
      dispatch_pending <= dispatch_pending_next;
      block_loud       <= block_loud_next;
      written_extent   <= written_extent_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/triggered_audio_capture_controller.sv */
// Top level of the triggered audio capture controller.
// Accepts one item per clock while not held off and returns one result per item:
// the item is held in an input register, the capture state and the frame store
// are updated from it as it passes on to the result register, and the result register
// (together with the store's registered read port) presents the outcome. The
// throughput is set by the single-port frame store, which takes either the
// frame write or the readback of one item per cycle. Results may be held off
// by out_ready; the input side keeps accepting while the input register is empty
// or the result register is free to load. The store is not cleared after reset; no
// read ever returns an entry beyond the written extent, so no clearing pass is needed.
`default_nettype none

module triggered_audio_capture_controller #(
  parameter int STORE_DEPTH   = 65536,
  parameter int CHANNEL_COUNT = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [tacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tacc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire tacc_pkg::in_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tacc_pkg::out_item_t                 out_item
);

  localparam int SB      = tacc_pkg::SAMPLE_BITS;
  localparam int MEM_W   = SB * ((CHANNEL_COUNT >= 2) ? 2 : 1);
  localparam int RWORD_W = tacc_pkg::WORD_W;

  logic                 s1_valid;
  tacc_pkg::in_item_t   s1_item;
  logic                 out_load;
  logic                 step;
  tacc_pkg::status_t    status;
  tacc_pkg::store_req_t store_req;
  logic                 read_hit;
  tacc_pkg::status_t    out_status;
  logic                 out_hit;
  logic [MEM_W-1:0]     mem_rdata;
  logic [RWORD_W-1:0]   rword;

  assign out_load = !out_valid || out_ready;
  assign step     = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (step) begin
      out_status <= status;
      out_hit    <= read_hit;
    end
  end

  tacc_ctrl #(
    .STORE_DEPTH   (STORE_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (s1_item),
    .status    (status),
    .store_req (store_req),
    .read_hit  (read_hit)
  );

  tacc_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (MEM_W)
  ) u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (mem_rdata)
  );

  // mono stores one channel; the right half then reads as zero
  assign rword = RWORD_W'(mem_rdata);

  always_comb begin
    out_item.mode             = out_status.mode;
    out_item.finalize_wanted  = out_status.finalize_wanted;
    out_item.analysis_pending = out_status.analysis_pending;
    out_item.finalize_ok      = out_status.finalize_ok;
    out_item.captured_frames  = out_status.captured_frames;
    out_item.read_left        = out_hit ? rword[SB-1:0] : '0;
    out_item.read_right       = out_hit ? rword[RWORD_W-1:SB] : '0;
  end

  a_ok_means_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.finalize_ok |->
      out_item.mode == tacc_pkg::MODE_DONE && out_item.analysis_pending)
    else $error("successful finalize without completed capture");

  a_pending_iff_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.mode == tacc_pkg::MODE_DONE) == out_item.analysis_pending))
    else $error("dispatch pending out of step with complete mode");

  a_read_zero_off_read: assert property (@(posedge clk) disable iff (rst)
    step && s1_item.func != tacc_pkg::FUNC_READ |=>
      out_item.read_left == '0 && out_item.read_right == '0)
    else $error("read data on an item that is not a read");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the triggered audio capture controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 65536;
  localparam int unsigned FULL_SCALE = 8388608;
  localparam logic [tacc_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [tacc_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
  localparam int LONG_HOLD = 60;
  localparam int PHASE_ITEMS = 60;

  // Tracks the capture state and the frame store, one status per accepted item.
  class capture_tracker;
    logic [tacc_pkg::THR_W-1:0]  threshold;
    logic [tacc_pkg::POS_W-1:0]  limit_reg;
    logic [tacc_pkg::POS_W-1:0]  shortest;
    logic [tacc_pkg::STOP_W-1:0] stops_needed;
    logic [tacc_pkg::MODE_W-1:0] mode;
    logic [tacc_pkg::POS_W-1:0]  position;
    logic [tacc_pkg::POS_W-1:0]  final_len;
    logic [tacc_pkg::POS_W-1:0]  extent;
    logic [tacc_pkg::STOP_W-1:0] stopped;
    logic                        want_final;
    logic                        pending;
    logic                        loud;
    logic [tacc_pkg::WORD_W-1:0] frames [int unsigned];
    tacc_pkg::out_item_t         awaited_status [$];
    int                          mismatches;

    function new();
      threshold = '0;
      limit_reg = tacc_pkg::POS_W'(STORE_DEPTH);
      shortest = '0;
      stops_needed = 8'd1;
      mismatches = 0;
      clear(tacc_pkg::MODE_WAIT);
    endfunction

    function void clear(logic [tacc_pkg::MODE_W-1:0] next_mode);
      extent = '0;
      position = '0;
      final_len = '0;
      stopped = '0;
      pending = 1'b0;
      want_final = 1'b0;
      loud = 1'b0;
      mode = next_mode;
    endfunction

    function void set_reg(logic [tacc_pkg::CFG_IDX_W-1:0] idx,
                          logic [tacc_pkg::CFG_W-1:0] val);
      case (idx)
        tacc_pkg::CFG_LEVEL_THRESHOLD:  threshold = val[tacc_pkg::THR_W-1:0];
        tacc_pkg::CFG_CAPTURE_LIMIT:    limit_reg = val[tacc_pkg::POS_W-1:0];
        tacc_pkg::CFG_MIN_FRAMES:       shortest = val[tacc_pkg::POS_W-1:0];
        tacc_pkg::CFG_STOP_BLOCK_COUNT: stops_needed = val[tacc_pkg::STOP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [tacc_pkg::POS_W-1:0] usable();
      return (limit_reg > STORE_DEPTH) ? tacc_pkg::POS_W'(STORE_DEPTH) : limit_reg;
    endfunction

    function logic [tacc_pkg::SAMPLE_BITS:0] magnitude(
        logic signed [tacc_pkg::SAMPLE_BITS-1:0] s);
      logic [tacc_pkg::SAMPLE_BITS:0] v;
      v = {s[tacc_pkg::SAMPLE_BITS-1], s};
      return s[tacc_pkg::SAMPLE_BITS-1] ? -v : v;
    endfunction

    function void take_frame(tacc_pkg::in_item_t it);
      logic [tacc_pkg::POS_W-1:0] top;
      top = usable();
      if (pending) return;
      if (mode == tacc_pkg::MODE_WAIT) begin
        if (it.host_playing && (magnitude(it.sample_left) > threshold ||
                                magnitude(it.sample_right) > threshold))
          loud = 1'b1;
        if (it.block_end) begin
          if (it.host_playing && loud) begin
            position = '0;
            stopped = '0;
            want_final = 1'b0;
            mode = tacc_pkg::MODE_CAPT;
          end
          loud = 1'b0;
        end
      end else if (mode == tacc_pkg::MODE_CAPT) begin
        if (it.block_end) loud = 1'b0;
        if (it.host_playing) begin
          stopped = '0;
          if (position < top) begin
            frames[position] = {it.sample_right, it.sample_left};
            position++;
            if (extent < position) extent = position;
          end
          if (position >= top) want_final = 1'b1;
        end else if (it.block_end) begin
          // saturate the stopped-block run
          if (stopped != 8'hFF) stopped++;
          if (stopped >= stops_needed) want_final = 1'b1;
        end
      end
    endfunction

    function void note_item(tacc_pkg::in_item_t it);
      tacc_pkg::out_item_t r;
      logic [tacc_pkg::WORD_W-1:0] w;
      r = '0;
      case (it.func)
        tacc_pkg::FUNC_FRAME: take_frame(it);
        tacc_pkg::FUNC_FINALIZE: begin
          if (mode == tacc_pkg::MODE_CAPT) begin
            if (position < shortest) begin
              clear(tacc_pkg::MODE_WAIT);
            end else begin
              final_len = position;
              pending = 1'b1;
              want_final = 1'b0;
              loud = 1'b0;
              mode = tacc_pkg::MODE_DONE;
              r.finalize_ok = 1'b1;
            end
          end
        end
        tacc_pkg::FUNC_DISPATCH: begin
          pending = 1'b0;
          want_final = 1'b0;
          stopped = '0;
          loud = 1'b0;
          mode = tacc_pkg::MODE_WAIT;
        end
        tacc_pkg::FUNC_STOP: clear(tacc_pkg::MODE_IDLE);
        tacc_pkg::FUNC_REARM: clear(tacc_pkg::MODE_WAIT);
        tacc_pkg::FUNC_READ: begin
          if (it.read_index < extent && it.read_index < usable()) begin
            w = frames[it.read_index];
            r.read_left = w[tacc_pkg::SAMPLE_BITS-1:0];
            r.read_right = w[tacc_pkg::WORD_W-1:tacc_pkg::SAMPLE_BITS];
          end
        end
        default: ;
      endcase
      r.mode = mode;
      r.finalize_wanted = want_final;
      r.analysis_pending = pending;
      r.captured_frames = (mode == tacc_pkg::MODE_DONE) ? final_len : position;
      awaited_status.push_back(r);
    endfunction

    function void compare(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(tacc_pkg::out_item_t got);
      tacc_pkg::out_item_t want;
      if (awaited_status.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        mismatches++;
        return;
      end
      want = awaited_status.pop_front();
      compare("mode", want.mode, got.mode);
      compare("finalize_wanted", want.finalize_wanted, got.finalize_wanted);
      compare("analysis_pending", want.analysis_pending, got.analysis_pending);
      compare("finalize_ok", want.finalize_ok, got.finalize_ok);
      compare("captured_frames", want.captured_frames, got.captured_frames);
      compare("read_left", want.read_left, got.read_left);
      compare("read_right", want.read_right, got.read_right);
    endfunction

    function int outstanding();
      return awaited_status.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [tacc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tacc_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  tacc_pkg::in_item_t             in_item = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  tacc_pkg::out_item_t            out_item;

  capture_tracker tracker;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int          hold_asked = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned level_now = 0;
  int unsigned limit_now = STORE_DEPTH;

  triggered_audio_capture_controller dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_item(in_item);
      if (out_valid && out_ready) tracker.check_result(out_item);
    end
  end

  function automatic logic signed [tacc_pkg::SAMPLE_BITS-1:0] any_sample();
    return tacc_pkg::SAMPLE_BITS'($urandom);
  endfunction

  // Magnitude at or below the threshold.
  function automatic logic signed [tacc_pkg::SAMPLE_BITS-1:0] quiet_sample();
    int unsigned m;
    m = $urandom_range(level_now, 0);
    return $urandom_range(1) ? tacc_pkg::SAMPLE_BITS'(m)
                             : tacc_pkg::SAMPLE_BITS'(-int'(m));
  endfunction

  // Magnitude strictly above the threshold; full scale only exists as negative.
  function automatic logic signed [tacc_pkg::SAMPLE_BITS-1:0] loud_sample();
    int unsigned m;
    m = $urandom_range(FULL_SCALE, level_now + 1);
    if (m == FULL_SCALE || $urandom_range(1)) return tacc_pkg::SAMPLE_BITS'(-int'(m));
    return tacc_pkg::SAMPLE_BITS'(m);
  endfunction

  task automatic send_item(tacc_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_frame(logic signed [tacc_pkg::SAMPLE_BITS-1:0] left,
                            logic signed [tacc_pkg::SAMPLE_BITS-1:0] right,
                            logic playing, logic last);
    tacc_pkg::in_item_t it;
    it.func = tacc_pkg::FUNC_FRAME;
    it.sample_left = left;
    it.sample_right = right;
    it.host_playing = playing;
    it.block_end = last;
    it.read_index = tacc_pkg::INDEX_W'($urandom);
    send_item(it);
  endtask

  task automatic send_command(logic [tacc_pkg::FUNC_W-1:0] func,
                              logic [tacc_pkg::INDEX_W-1:0] idx);
    tacc_pkg::in_item_t it;
    it.func = func;
    it.sample_left = any_sample();
    it.sample_right = any_sample();
    it.host_playing = 1'($urandom);
    it.block_end = 1'($urandom);
    it.read_index = idx;
    send_item(it);
  endtask

  task automatic send_noise();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    send_item(raw[$bits(tacc_pkg::in_item_t)-1:0]);
  endtask

  // Hold the input and wait for every outstanding status.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  task automatic put_reg(logic [tacc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= tacc_pkg::CFG_W'(val);
    @(posedge clk);
    tracker.set_reg(idx, tacc_pkg::CFG_W'(val));
  endtask

  task automatic configure(int unsigned thr, int unsigned lim, int unsigned minf,
                           int unsigned stops);
    put_reg(tacc_pkg::CFG_LEVEL_THRESHOLD, thr);
    put_reg(tacc_pkg::CFG_CAPTURE_LIMIT, lim);
    put_reg(tacc_pkg::CFG_MIN_FRAMES, minf);
    put_reg(tacc_pkg::CFG_STOP_BLOCK_COUNT, stops);
    cfg_write <= 1'b0;
    level_now = thr;
    limit_now = lim;
  endtask

  // One capture attempt: clear or dispatch, quiet block, arming block, capture, finalize, read-back, dispatch.
  task automatic run_capture();
    int   n;
    int   loud_at;
    logic play;
    logic last;
    case ($urandom_range(9))
      0: begin
        send_command(tacc_pkg::FUNC_STOP, tacc_pkg::INDEX_W'($urandom));
        send_frame(loud_sample(), loud_sample(), 1'b1, 1'b1);
        send_command(tacc_pkg::FUNC_REARM, tacc_pkg::INDEX_W'($urandom));
      end
      1: send_command(tacc_pkg::FUNC_DISPATCH, tacc_pkg::INDEX_W'($urandom));
      default: send_command(tacc_pkg::FUNC_REARM, tacc_pkg::INDEX_W'($urandom));
    endcase
    n = $urandom_range(3);
    for (int i = 0; i < n; i++)
      send_frame(quiet_sample(), quiet_sample(), 1'($urandom), i == n - 1);
    n = $urandom_range(3, 1);
    loud_at = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1);
      // the closing frame usually plays, so the block arms
      play = last ? ($urandom_range(7) != 0) : 1'($urandom);
      if (i == loud_at && !last) play = 1'b1;
      if (i != loud_at)
        send_frame(quiet_sample(), quiet_sample(), play, last);
      else if ($urandom_range(1))
        send_frame(loud_sample(), quiet_sample(), play, last);
      else
        send_frame(quiet_sample(), loud_sample(), play, last);
    end
    n = $urandom_range((limit_now < 16) ? limit_now + 4 : 20);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1: repeat ($urandom_range(3, 1))
          send_frame(any_sample(), any_sample(), 1'b0, $urandom_range(3) != 0);
        2: send_command(tacc_pkg::FUNC_READ, tacc_pkg::INDEX_W'($urandom_range(24)));
        3: send_noise();
        default: send_frame(any_sample(), any_sample(), 1'b1, $urandom_range(3) == 0);
      endcase
    end
    if ($urandom_range(9) < 7)
      send_command(tacc_pkg::FUNC_FINALIZE, tacc_pkg::INDEX_W'($urandom));
    if ($urandom_range(3) == 0) send_frame(loud_sample(), any_sample(), 1'b1, 1'b1);
    repeat ($urandom_range(3))
      send_command(tacc_pkg::FUNC_READ,
                   ($urandom_range(3) == 0) ? tacc_pkg::INDEX_W'($urandom)
                                            : tacc_pkg::INDEX_W'($urandom_range(24)));
    if ($urandom_range(9) < 6)
      send_command(tacc_pkg::FUNC_DISPATCH, tacc_pkg::INDEX_W'($urandom));
  endtask

  initial begin
    int phase_end;
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(100, 4, 2, 2);
    send_command(tacc_pkg::FUNC_READ, 16'h0000);
    send_command(tacc_pkg::FUNC_READ, 16'hFFFF);
    send_frame(24'sd100, -24'sd100, 1'b1, 1'b1);       // at the threshold: not loud
    send_frame(-24'sd101, 24'sd0, 1'b1, 1'b0);
    send_frame(24'sd0, 24'sd0, 1'b0, 1'b1);            // loud block ends stopped: no arm
    send_frame(24'sd0, 24'sd101, 1'b1, 1'b1);
    send_command(tacc_pkg::FUNC_FINALIZE, 16'h0000);   // too short: re-arm
    send_frame(24'sh7FFFFF, 24'sd0, 1'b1, 1'b1);
    send_frame(24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0);
    send_frame(24'sh800000, 24'sh7FFFFF, 1'b1, 1'b1);
    send_frame(24'sd0, 24'sd0, 1'b0, 1'b1);
    send_frame(24'sd0, 24'sd0, 1'b0, 1'b1);
    send_frame(-24'sd1, 24'sd1, 1'b1, 1'b0);
    send_frame(24'sh555555, 24'shAAAAAA, 1'b1, 1'b0);  // store full
    send_frame(24'sd1, 24'sd1, 1'b1, 1'b1);
    send_command(tacc_pkg::FUNC_FINALIZE, 16'h0000);
    send_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b1);
    send_command(tacc_pkg::FUNC_READ, 16'd3);
    send_command(tacc_pkg::FUNC_READ, 16'd4);
    send_command(FUNC_SPARE_6, 16'h0000);
    send_command(FUNC_SPARE_7, 16'hFFFF);
    send_command(tacc_pkg::FUNC_DISPATCH, 16'h0000);
    send_command(tacc_pkg::FUNC_READ, 16'd1);          // old capture still readable
    send_command(tacc_pkg::FUNC_STOP, 16'h0000);
    send_frame(24'sh800000, 24'sd0, 1'b1, 1'b1);
    send_command(tacc_pkg::FUNC_FINALIZE, 16'h0000);
    send_command(tacc_pkg::FUNC_READ, 16'h0000);
    send_command(tacc_pkg::FUNC_REARM, 16'h0000);

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin
          configure(4000, STORE_DEPTH, 0, 1);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          configure(FULL_SCALE - 1, 0, STORE_DEPTH, 255);
          send_idle_pct = 51;
          stall_pct = 0;
        end
        2: begin
          configure(0, 8, 3, 2);
          send_idle_pct = 0;
          stall_pct = 51;
        end
        3: begin
          configure($urandom_range(FULL_SCALE - 2, 1), 16, 5, 3);
          send_idle_pct = 7;
          stall_pct = 7;
        end
        default: begin
          // shrink the limit below the last capture's extent
          configure(1000, 5, 1, 1);
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      repeat (3)
        send_command(tacc_pkg::FUNC_READ, tacc_pkg::INDEX_W'($urandom_range(24)));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (p == 0 && hold_asked == 0 && items_sent >= phase_end - 60) hold_asked++;
        run_capture();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hdl/tacc_pkg.sv
hdl/tacc_store.sv
hdl/tacc_ctrl.sv
hdl/triggered_audio_capture_controller.sv
dv/tb.sv
